// ----- rtl/trvg_pkg.sv -----
// ----------------------------------------------------------------------------
// trvg_pkg
// Shared constants, types, generator step and constant tables of the
// triggered random value generator.
// ----------------------------------------------------------------------------
`default_nettype none

package trvg_pkg;

	localparam int FRAC_BITS       = 16;
	localparam int TABLE_ADDR_BITS = 10;
	localparam int VAL_W           = 31;
	localparam int LVL_W           = 32;
	localparam int SEED_W          = 17;
	localparam int CFG_IDX_W       = 3;
	localparam int MUL_W           = 34;
	localparam int PROD_W          = 2 * MUL_W;

	localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOW     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RANGE_HIGH    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAUSSIAN_MODE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SEED_VALUE    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FREE_RUNNING  = 3'd4;

	localparam int LN_DEPTH  = 1 << TABLE_ADDR_BITS;
	localparam int COS_Q     = 1 << (TABLE_ADDR_BITS - 2);
	localparam int COS_DEPTH = COS_Q + 1;

	localparam logic [31:0] LN2_Q32     = 32'd2977044472;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [63:0] ONE_Q30     = 64'd1 << 30;
	localparam logic [31:0] GEN_RESET   = 32'd12345;
	localparam logic [SEED_W-1:0] SEED_RESET = 17'd12345;
	localparam logic signed [LVL_W-1:0] TRIG_LEVEL = 32'sd1 <<< (FRAC_BITS - 1);
	localparam logic [VAL_W-1:0] HIGH_RESET = 31'd1 << FRAC_BITS;
	// (2^34 + 2) / 3: exact floor(n / 3) as (n * DIV3_RECIP) >> 34 for n < 2^33
	localparam logic [MUL_W-1:0] DIV3_RECIP = 34'd5726623062;

	typedef logic signed [VAL_W-1:0] val_t;

	typedef struct packed {
		logic              start;
		logic              load_seed;
		logic [SEED_W-1:0] seed;
	} trvg_cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
	} trvg_stat_t;

	typedef logic [31:0] ln_rom_t  [LN_DEPTH];
	typedef logic [30:0] cos_rom_t [COS_DEPTH];

	function automatic logic [31:0] xs_next(input logic [31:0] x_in);
		logic [31:0] x;
		x = x_in;
		x = x ^ (x << 13);
		x = x ^ (x >> 17);
		x = x ^ (x << 5);
		return x;
	endfunction

	function automatic logic [63:0] udiv(input logic [63:0] num, input logic [63:0] den);
		logic [64:0] rem;
		logic [63:0] quo;
		rem = '0;
		quo = '0;
		for (int i = 63; i >= 0; i--) begin
			rem = {rem[63:0], num[i]};
			if (rem >= {1'b0, den}) begin
				rem    = rem - {1'b0, den};
				quo[i] = 1'b1;
			end
		end
		return quo;
	endfunction

	function automatic logic [31:0] ln_entry(input logic [63:0] k);
		logic [63:0] y;
		logic [63:0] y2;
		logic [63:0] t;
		logic [63:0] sum;
		logic [63:0] n;
		logic [63:0] r;
		y   = udiv(k << 32, (64'd1 << (TABLE_ADDR_BITS + 1)) + k);
		y2  = (y * y) >> 32;
		t   = y;
		sum = '0;
		n   = 64'd1;
		for (int i = 0; i < 64; i++) begin
			if (t != 0) begin
				sum = sum + udiv(t, n);
				t   = (t * y2) >> 32;
				n   = n + 64'd2;
			end
		end
		r = sum << 1;
		return r[31:0];
	endfunction

	function automatic logic [30:0] cos_quarter(input logic [63:0] j);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic signed [63:0] sum;
		logic stop;
		x    = (HALF_PI_Q30 * j) >> (TABLE_ADDR_BITS - 2);
		x2   = (x * x) >> 30;
		t    = ONE_Q30;
		sum  = $signed(ONE_Q30);
		stop = 1'b0;
		for (int k = 1; k < 40; k++) begin
			if (!stop) begin
				t = udiv((t * x2) >> 30, 64'((2 * k - 1) * (2 * k)));
				if (t == 0) begin
					stop = 1'b1;
				end else if ((k % 2) == 1) begin
					sum = sum - $signed(t);
				end else begin
					sum = sum + $signed(t);
				end
			end
		end
		if (sum < 0) begin
			sum = '0;
		end
		if (sum > $signed(ONE_Q30)) begin
			sum = $signed(ONE_Q30);
		end
		return sum[30:0];
	endfunction

	function automatic ln_rom_t build_ln();
		ln_rom_t r;
		for (int k = 0; k < LN_DEPTH; k++) begin
			r[k] = ln_entry(64'(k));
		end
		return r;
	endfunction

	function automatic cos_rom_t build_cos();
		cos_rom_t r;
		for (int j = 0; j < COS_DEPTH; j++) begin
			r[j] = cos_quarter(64'(j));
		end
		return r;
	endfunction

	localparam ln_rom_t  LN_ROM  = build_ln();
	localparam cos_rom_t COS_ROM = build_cos();

endpackage

`default_nettype wire

// ----- rtl/trvg_mul.sv -----
// ----------------------------------------------------------------------------
// trvg_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module trvg_mul (
	input  wire logic                                   clk,
	input  wire logic signed [trvg_pkg::MUL_W-1:0]      a,
	input  wire logic signed [trvg_pkg::MUL_W-1:0]      b,
	output logic signed      [trvg_pkg::PROD_W-1:0]     prod
);
	import trvg_pkg::*;

	logic signed [PROD_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end

	assign prod = prod_q;

endmodule

`default_nettype wire

// ----- rtl/trvg_core.sv -----
// ----------------------------------------------------------------------------
// trvg_core
// Draw sequencer: xorshift state, uniform scaling and the Box-Muller steps
// (normalize, table read, isqrt, scale, divide by three) on one multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module trvg_core (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire trvg_pkg::trvg_cmd_t     cmd,
	input  wire trvg_pkg::val_t          range_low,
	input  wire trvg_pkg::val_t          range_high,
	input  wire logic                    gaussian_mode,
	output trvg_pkg::trvg_stat_t         stat,
	output trvg_pkg::val_t               value
);
	import trvg_pkg::*;

	localparam int TA = TABLE_ADDR_BITS;

	typedef enum logic [3:0] {
		S_IDLE, S_R1, S_UMUL, S_UDIV, S_R2, S_NORM, S_LN, S_WMUL,
		S_W, S_SQRT, S_CMUL, S_Z, S_ZMUL, S_ZD, S_DIV3, S_GFIN
	} state_t;

	state_t             state_q;
	logic [31:0]        gen_q;
	logic [32:0]        norm_q;
	logic [5:0]         shcnt_q;
	logic [TA-1:0]      r2idx_q;
	logic [31:0]        ln_q;
	logic [30:0]        cmag_q;
	logic               cneg_q;
	logic [39:0]        acc_q;
	logic [39:0]        res_q;
	logic [39:0]        bit_q;
	logic signed [21:0] z_q;
	logic               zneg_q;
	logic [32:0]        quo_q;
	val_t               value_q;
	logic               done_q;

	logic signed [MUL_W-1:0]  mul_a;
	logic signed [MUL_W-1:0]  mul_b;
	logic signed [PROD_W-1:0] prod;

	logic signed [31:0] lo32;
	logic signed [31:0] hi32;
	logic signed [31:0] d;
	logic [31:0]        nx;
	logic               pneg;
	logic [63:0]        pabs;
	logic [32:0]        uq;
	logic [33:0]        ut;
	logic [32:0]        uq1;
	logic signed [33:0] uqs;
	logic signed [33:0] usum;
	logic [37:0]        wdiff;
	logic [39:0]        rb;
	logic [20:0]        mag;
	logic [1:0]         quad;
	logic [TA-2:0]      jraw;
	logic [TA-2:0]      jsel;
	logic signed [36:0] qv;
	logic signed [32:0] msum;
	logic signed [32:0] mid;
	logic signed [37:0] vsum;
	logic [31:0]        seed_load;

	assign lo32 = {range_low[VAL_W-1], range_low};
	assign hi32 = {range_high[VAL_W-1], range_high};
	assign d    = hi32 - lo32;
	assign nx   = xs_next(gen_q);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_UMUL: begin
				mul_a = {{2{d[31]}}, d};
				mul_b = {2'b00, norm_q[31:0]};
			end
			S_WMUL: begin
				mul_a = {28'd0, shcnt_q};
				mul_b = {2'b00, LN2_Q32};
			end
			S_CMUL: begin
				mul_a = {14'd0, res_q[19:0]};
				mul_b = {3'd0, cmag_q};
			end
			S_ZMUL: begin
				mul_a = {{12{z_q[21]}}, z_q};
				mul_b = {{2{d[31]}}, d};
			end
			S_DIV3: begin
				mul_a = {1'b0, quo_q};
				mul_b = DIV3_RECIP;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	trvg_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	always_comb begin
		pneg  = prod[PROD_W-1];
		pabs  = pneg ? 64'(-prod) : prod[63:0];
		uq    = {1'b0, pabs[63:32]};
		ut    = {1'b0, uq} + {2'b00, pabs[31:0]};
		uq1   = uq + {32'd0, (ut >= 34'h0FFFFFFFF)};
		uqs   = pneg ? -$signed({1'b0, uq1}) : $signed({1'b0, uq1});
		usum  = $signed({{2{lo32[31]}}, lo32}) + uqs;
		wdiff = prod[37:0] - {6'd0, ln_q};
		rb    = res_q + bit_q;
		mag   = prod[50:30];
		quad  = r2idx_q[TA-1:TA-2];
		jraw  = {1'b0, r2idx_q[TA-3:0]};
		jsel  = (quad == 2'd1 || quad == 2'd3) ? (TA-1)'(COS_Q) - jraw : jraw;
		qv    = zneg_q ? -$signed({4'd0, prod[66:34]}) : $signed({4'd0, prod[66:34]});
		msum  = $signed({lo32[31], lo32}) + $signed({hi32[31], hi32});
		mid   = (msum + $signed({32'd0, msum[32]})) >>> 1;
		vsum  = $signed({{5{mid[32]}}, mid}) + $signed({qv[36], qv});
		seed_load = (cmd.seed == '0) ? 32'd1 : {15'd0, cmd.seed};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			gen_q   <= GEN_RESET;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (cmd.start) begin
						if (cmd.load_seed) begin
							gen_q <= seed_load;
						end
						state_q <= S_R1;
					end
				end
				S_R1: begin
					gen_q   <= nx;
					norm_q  <= {1'b0, nx};
					state_q <= gaussian_mode ? S_R2 : S_UMUL;
				end
				S_UMUL: state_q <= S_UDIV;
				S_UDIV: begin
					value_q <= usum[VAL_W-1:0];
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				S_R2: begin
					gen_q   <= nx;
					r2idx_q <= nx[31:32-TA];
					norm_q  <= norm_q + 33'd1;
					shcnt_q <= '0;
					state_q <= S_NORM;
				end
				S_NORM: begin
					if (norm_q[32]) begin
						state_q <= S_LN;
					end else begin
						norm_q  <= {norm_q[31:0], 1'b0};
						shcnt_q <= shcnt_q + 6'd1;
					end
				end
				S_LN: begin
					ln_q    <= LN_ROM[norm_q[31:32-TA]];
					cmag_q  <= COS_ROM[jsel];
					cneg_q  <= (quad == 2'd1 || quad == 2'd2);
					state_q <= S_WMUL;
				end
				S_WMUL: state_q <= S_W;
				S_W: begin
					acc_q   <= {1'b0, wdiff, 1'b0};
					res_q   <= '0;
					bit_q   <= 40'd1 << 38;
					state_q <= S_SQRT;
				end
				S_SQRT: begin
					if (acc_q >= rb) begin
						acc_q <= acc_q - rb;
						res_q <= (res_q >> 1) + bit_q;
					end else begin
						res_q <= res_q >> 1;
					end
					bit_q <= bit_q >> 2;
					if (bit_q[0]) begin
						state_q <= S_CMUL;
					end
				end
				S_CMUL: state_q <= S_Z;
				S_Z: begin
					z_q     <= cneg_q ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
					state_q <= S_ZMUL;
				end
				S_ZMUL: state_q <= S_ZD;
				S_ZD: begin
					zneg_q  <= pneg;
					quo_q   <= pabs[49:17];
					state_q <= S_DIV3;
				end
				S_DIV3: state_q <= S_GFIN;
				S_GFIN: begin
					priority if (vsum < $signed({{6{lo32[31]}}, lo32})) begin
						value_q <= range_low;
					end else if (vsum > $signed({{6{hi32[31]}}, hi32})) begin
						value_q <= range_high;
					end else begin
						value_q <= vsum[VAL_W-1:0];
					end
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign stat.busy = (state_q != S_IDLE);
	assign stat.done = done_q;
	assign value     = value_q;

endmodule

`default_nettype wire

// ----- rtl/triggered_random_value_generator_top.sv -----
// ----------------------------------------------------------------------------
// triggered_random_value_generator_top
// Per-tick held random value in signed Q15.16: xorshift32 draws, uniform or
// Box-Muller gaussian, seeded on the first tick, redrawn in free-run mode or
// on a rising trigger edge.
//
//   channel  signals                               direction
//   input    in_valid, in_ready, trigger_level     in
//   output   out_valid, out_ready, value           out
//   config   cfg_en, cfg_index, cfg_data           in
//
// A uniform draw is one scaling multiply; a gaussian draw varies with the
// normalize loop and the 20-step isqrt on the shared multiplier datapath; the
// divide by three is one reciprocal multiply. The first tick runs the seeding
// draw and then possibly a second one. A tick with no draw goes to emit. Reset
// clears all control state at once, with no clearing pass. A stalled output
// holds its value; the next tick is taken meanwhile and waits to emit.
// ----------------------------------------------------------------------------
`default_nettype none

module triggered_random_value_generator_top (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	output logic                                      in_ready,
	input  wire logic signed [trvg_pkg::LVL_W-1:0]    trigger_level,
	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output trvg_pkg::val_t                            value,
	input  wire logic                                 cfg_en,
	input  wire logic [trvg_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [trvg_pkg::VAL_W-1:0]           cfg_data
);
	import trvg_pkg::*;

	typedef enum logic [1:0] {ST_IDLE, ST_DRAW1, ST_DRAW2, ST_EMIT} state_t;

	state_t            state_q;
	val_t              lo_q;
	val_t              hi_q;
	logic              gauss_q;
	logic [SEED_W-1:0] seed_q;
	logic              free_q;
	logic              seeded_q;
	logic              trig_was_q;
	logic              second_q;
	val_t              held_q;
	val_t              value_q;
	logic              out_valid_q;

	trvg_cmd_t  cmd;
	trvg_stat_t stat;
	val_t       core_value;
	logic       accept;
	logic       trig;
	logic       rising;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign trig     = (trigger_level > TRIG_LEVEL);
	assign rising   = trig && !trig_was_q;

	always_comb begin
		cmd.start     = (accept && (!seeded_q || free_q || rising)) ||
		                (state_q == ST_DRAW1 && stat.done && second_q);
		cmd.load_seed = accept && !seeded_q;
		cmd.seed      = seed_q;
	end

	trvg_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.range_low     (lo_q),
		.range_high    (hi_q),
		.gaussian_mode (gauss_q),
		.stat          (stat),
		.value         (core_value)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_q    <= '0;
			hi_q    <= HIGH_RESET;
			gauss_q <= 1'b0;
			seed_q  <= SEED_RESET;
			free_q  <= 1'b1;
		end else if (cfg_en) begin
			unique case (cfg_index)
				REG_RANGE_LOW:     lo_q    <= cfg_data;
				REG_RANGE_HIGH:    hi_q    <= cfg_data;
				REG_GAUSSIAN_MODE: gauss_q <= cfg_data[0];
				REG_SEED_VALUE:    seed_q  <= cfg_data[SEED_W-1:0];
				REG_FREE_RUNNING:  free_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			seeded_q    <= 1'b0;
			trig_was_q  <= 1'b0;
			second_q    <= 1'b0;
			held_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_EMIT && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						trig_was_q <= trig;
						second_q   <= free_q || rising;
						seeded_q   <= 1'b1;
						priority if (!seeded_q) begin
							state_q <= ST_DRAW1;
						end else if (free_q || rising) begin
							state_q <= ST_DRAW2;
						end else begin
							state_q <= ST_EMIT;
						end
					end
				end
				ST_DRAW1: begin
					if (stat.done) begin
						held_q  <= core_value;
						state_q <= second_q ? ST_DRAW2 : ST_EMIT;
					end
				end
				ST_DRAW2: begin
					if (stat.done) begin
						held_q  <= core_value;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (!out_valid_q || out_ready) begin
						value_q <= held_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign value     = value_q;

	a_ready_core_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !stat.busy)
		else $error("input taken while a draw is in flight");

	a_done_in_draw: assert property (@(posedge clk) disable iff (!arst_n)
		stat.done |-> (state_q == ST_DRAW1 || state_q == ST_DRAW2))
		else $error("draw finished outside a draw state");

	a_seeded_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> seeded_q)
		else $error("generator not seeded after first transfer");

endmodule

`default_nettype wire

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// Triggered random value generator testbench
// Sends trigger samples in random bursts under random output back-pressure.
// It predicts each held value with a local xorshift, uniform and Box-Muller
// model and compares every output transfer in order. It first runs short
// directed tables and then random phases, each under a new register setting.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import trvg_pkg::*;

	localparam longint LIMIT_CYCLES = 2000000;
	localparam int     SETTLE       = 300;
	localparam longint VMAX         = 655360000;
	localparam logic signed [31:0] TRIG_HALF = 32'sd32768;

	logic                          clk;
	logic                          arst_n;
	logic                          in_valid;
	logic                          in_ready;
	logic signed [LVL_W-1:0]       trigger_level;
	logic                          out_valid;
	logic                          out_ready;
	val_t                          value;
	logic                          cfg_en;
	logic [CFG_IDX_W-1:0]          cfg_index;
	logic [VAL_W-1:0]              cfg_data;

	triggered_random_value_generator_top DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .trigger_level(trigger_level),
		.out_valid(out_valid), .out_ready(out_ready), .value(value),
		.cfg_en(cfg_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	typedef struct {
		logic signed [31:0] trig;
		bit                 fixed;
		longint             held;
	} tick_row_t;

	// model state and registers
	longint       lo_reg, hi_reg;
	bit           gauss_reg, free_reg;
	logic [16:0]  seed_reg;
	logic [31:0]  rng_state;
	longint       held_now;
	bit           trig_was_high, seeded;

	longint unsigned ln_q32 [LN_DEPTH];
	longint          cos_q30 [COS_DEPTH];

	longint  held_expected [$];
	int      mismatches;
	longint  cycles;
	int      stall_pct;
	int      burst_left;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic longint unsigned ln_term(longint unsigned k);
		longint unsigned y, y2, t, sum, n;
		y   = (k << 32) / ((64'd1 << (TABLE_ADDR_BITS + 1)) + k);
		y2  = (y * y) >> 32;
		t   = y;
		sum = 0;
		n   = 1;
		while (t != 0) begin
			sum += t / n;
			t = (t * y2) >> 32;
			n += 2;
		end
		return 2 * sum;
	endfunction

	function automatic longint cos_term(longint unsigned j);
		longint unsigned x, x2, t;
		longint          sum;
		x   = (64'd1686629713 * j) / COS_Q;
		x2  = (x * x) >> 30;
		t   = 64'd1 << 30;
		sum = 64'sd1 << 30;
		for (int k = 1; k < 40; k++) begin
			t = ((t * x2) >> 30) / longint'((2 * k - 1) * (2 * k));
			if (t == 0) break;
			if (k % 2 == 1) sum -= longint'(t);
			else sum += longint'(t);
		end
		if (sum < 0) sum = 0;
		if (sum > (64'sd1 << 30)) sum = 64'sd1 << 30;
		return sum;
	endfunction

	function automatic longint unsigned root_floor(longint unsigned v);
		longint unsigned res, bitv;
		res  = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic logic [31:0] advance_rng();
		logic [31:0] x;
		x = rng_state;
		x ^= x << 13;
		x ^= x >> 17;
		x ^= x << 5;
		rng_state = x;
		return x;
	endfunction

	function automatic longint cos_of_index(int idx);
		int quad, j;
		quad = idx >> (TABLE_ADDR_BITS - 2);
		j    = idx & (COS_Q - 1);
		case (quad & 3)
			0: return cos_q30[j];
			1: return -cos_q30[COS_Q - j];
			2: return -cos_q30[j];
			default: return cos_q30[COS_Q - j];
		endcase
	endfunction

	function automatic longint draw_value();
		longint          d, c, z, mid, v;
		longint unsigned r1, r2, m, k, w, s, mag;
		int              e;
		d = hi_reg - lo_reg;
		if (!gauss_reg) begin
			r1 = advance_rng();
			return lo_reg + (d * longint'(r1)) / 64'sd4294967295;
		end
		r1 = advance_rng();
		r2 = advance_rng();
		m  = r1 + 1;
		e  = 0;
		while ((m >> (e + 1)) != 0) e++;
		if (e >= TABLE_ADDR_BITS) k = (m >> (e - TABLE_ADDR_BITS)) & (LN_DEPTH - 1);
		else k = (m << (TABLE_ADDR_BITS - e)) & (LN_DEPTH - 1);
		w   = 2 * (longint'(32 - e) * 64'd2977044472 - ln_q32[k]);
		s   = root_floor(w);
		c   = cos_of_index(int'(r2 >> (32 - TABLE_ADDR_BITS)));
		mag = (s * longint'(c < 0 ? -c : c)) >> 30;
		z   = c < 0 ? -longint'(mag) : longint'(mag);
		mid = (lo_reg + hi_reg) / 2;
		v   = mid + (z * d) / (64'sd6 * 64'sd65536);
		if (v < lo_reg) return lo_reg;
		if (v > hi_reg) return hi_reg;
		return v;
	endfunction

	function automatic longint tick_value(logic signed [31:0] trig);
		bit high_now, rising;
		if (!seeded) begin
			rng_state = {15'd0, seed_reg};
			if (rng_state == 0) rng_state = 1;
			held_now = draw_value();
			seeded   = 1'b1;
		end
		high_now      = trig > TRIG_HALF;
		rising        = high_now && !trig_was_high;
		trig_was_high = high_now;
		if (free_reg || rising) held_now = draw_value();
		return held_now;
	endfunction

	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, longint data);
		cfg_en    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= VAL_W'(data);
		case (idx)
			REG_RANGE_LOW:     lo_reg = longint'($signed(VAL_W'(data)));
			REG_RANGE_HIGH:    hi_reg = longint'($signed(VAL_W'(data)));
			REG_GAUSSIAN_MODE: gauss_reg = data[0];
			REG_SEED_VALUE:    seed_reg = data[16:0];
			REG_FREE_RUNNING:  free_reg = data[0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic cfg_done();
		cfg_en <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (held_expected.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic send_tick(logic signed [31:0] trig, bit fixed, longint held);
		longint pred;
		int     gap;
		in_valid      <= 1'b1;
		trigger_level <= trig;
		do @(posedge clk); while (!in_ready);
		pred = tick_value(trig);
		held_expected.insert(held_expected.size(), fixed ? held : pred);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 30);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end else begin
			burst_left--;
		end
	endtask

	function automatic longint pick_range();
		case ($urandom_range(0, 5))
			0: return -VMAX;
			1: return VMAX;
			2: return longint'($urandom_range(0, 200000)) - 100000;
			default: return longint'($urandom_range(0, 1310720000)) - VMAX;
		endcase
	endfunction

	function automatic logic signed [31:0] pick_trig();
		case ($urandom_range(0, 7))
			0: return TRIG_HALF;
			1: return TRIG_HALF + 1;
			2: return $signed($urandom());
			3: return $signed($urandom_range(0, 32768));
			default: return ($urandom_range(0, 1) != 0) ? 32'sd65536 : 32'sd0;
		endcase
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= stall_pct);
			if (out_valid && out_ready) begin
				if (held_expected.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected transfer: value=%0d", value);
				end else begin
					longint exp_held;
					exp_held = held_expected.pop_front();
					if (value !== VAL_W'(exp_held)) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected %0d, got %0d", exp_held, value);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if (cycles % 200 == 0)
			stall_pct <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 80);
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	tick_row_t directed [$];

	initial begin
		longint lo_v, hi_v;
		int     n_items;
		int     n_batch;
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		trigger_level = '0;
		out_ready     = 1'b0;
		cfg_en        = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		cycles        = 0;
		stall_pct     = 0;
		mismatches    = 0;
		burst_left    = 0;
		lo_reg = 0; hi_reg = 65536; gauss_reg = 0; seed_reg = 17'd12345; free_reg = 1;
		rng_state = 32'd12345; held_now = 0; trig_was_high = 0; seeded = 0;
		for (int k = 0; k < LN_DEPTH; k++) ln_q32[k] = ln_term(k);
		for (int j = 0; j < COS_DEPTH; j++) cos_q30[j] = cos_term(j);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// collapsed range: every draw lands on the bound
		cfg_write(REG_RANGE_LOW, 327680);
		cfg_write(REG_RANGE_HIGH, 327680);
		cfg_write(REG_GAUSSIAN_MODE, 0);
		cfg_write(REG_SEED_VALUE, 0);
		cfg_write(REG_FREE_RUNNING, 1);
		cfg_write(CFG_IDX_W'(5), 123);
		cfg_write(CFG_IDX_W'(7), 0);
		cfg_done();
		directed = '{
			'{32'sh7FFFFFFF, 1, 327680}, '{32'sh80000000, 1, 327680},
			'{32'sd0, 1, 327680}, '{32'sd32769, 1, 327680}, '{-32'sd1, 1, 327680}};
		foreach (directed[i]) send_tick(directed[i].trig, directed[i].fixed, directed[i].held);
		wait_drained();

		// range -VMAX to VMAX, gaussian, edge triggered
		cfg_write(REG_RANGE_LOW, -VMAX);
		cfg_write(REG_RANGE_HIGH, VMAX);
		cfg_write(REG_GAUSSIAN_MODE, 1);
		cfg_write(REG_FREE_RUNNING, 0);
		cfg_write(REG_SEED_VALUE, 99999);
		cfg_done();
		directed = '{
			'{32'sd0, 0, 0}, '{32'sd32768, 0, 0}, '{32'sd32769, 0, 0},
			'{32'sh7FFFFFFF, 0, 0}, '{32'sh80000000, 0, 0}, '{32'sd32769, 0, 0},
			'{-32'sd1, 0, 0}, '{32'sd65536, 0, 0}, '{32'sd0, 0, 0}, '{32'sd65536, 0, 0}};
		foreach (directed[i]) send_tick(directed[i].trig, directed[i].fixed, directed[i].held);
		wait_drained();

		// inverted range, uniform and gaussian
		cfg_write(REG_RANGE_LOW, VMAX);
		cfg_write(REG_RANGE_HIGH, -VMAX);
		cfg_write(REG_GAUSSIAN_MODE, 0);
		cfg_write(REG_FREE_RUNNING, 1);
		cfg_done();
		repeat (4) send_tick(pick_trig(), 0, 0);
		wait_drained();
		cfg_write(REG_GAUSSIAN_MODE, 1);
		cfg_done();
		repeat (4) send_tick(pick_trig(), 0, 0);
		wait_drained();

		n_items = 0;
		while (n_items < 800) begin
			lo_v = pick_range();
			hi_v = pick_range();
			if ($urandom_range(0, 3) != 0 && lo_v > hi_v) begin
				longint tmp_v;
				tmp_v = lo_v; lo_v = hi_v; hi_v = tmp_v;
			end
			cfg_write(REG_RANGE_LOW, lo_v);
			cfg_write(REG_RANGE_HIGH, hi_v);
			cfg_write(REG_GAUSSIAN_MODE, $urandom_range(0, 1));
			cfg_write(REG_FREE_RUNNING, $urandom_range(0, 1));
			cfg_write(REG_SEED_VALUE, $urandom_range(0, 131071));
			cfg_done();
			n_batch = $urandom_range(60, 140);
			if (n_batch > 800 - n_items)
				n_batch = 800 - n_items;
			repeat (n_batch) begin
				if ($urandom_range(0, 60) == 0) begin
					in_valid <= 1'b0;
					while (held_expected.size() != 0) @(posedge clk);
				end
				send_tick(pick_trig(), 0, 0);
				n_items++;
			end
			in_valid <= 1'b0;
			wait_drained();
		end

		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

`default_nettype wire

// ----- sim.f -----
rtl/trvg_pkg.sv
rtl/trvg_mul.sv
rtl/trvg_core.sv
rtl/triggered_random_value_generator_top.sv
test/tb_top.sv
